@@ rtl/core/utv_pkg.sv @@
// Package: shared constants, codes and types of the UTF-8 text validator.
`timescale 1ns / 1ps
`default_nettype none

package utv_pkg;

  // Counter sizing
  localparam int COUNT_BITS = 16;
  localparam int BYTE_CNT_W = COUNT_BITS + 1;
  localparam int LIMIT_W    = 16;
  localparam int CP_OUT_W   = 16;
  localparam int CMP_W      = (BYTE_CNT_W > LIMIT_W) ? BYTE_CNT_W : LIMIT_W;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CP_W       = 21;

  // Codepoint boundaries
  localparam logic [CP_W-1:0] CP_MIN_2     = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3     = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4     = 21'h010000;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_C0_END    = 21'h000020;
  localparam logic [CP_W-1:0] CP_DEL       = 21'h00007F;
  localparam logic [CP_W-1:0] CP_C1_HI     = 21'h00009F;
  localparam logic [CP_W-1:0] CP_TAB       = 21'h000009;
  localparam logic [CP_W-1:0] CP_NEWLINE   = 21'h00000A;

  typedef enum logic [2:0] {
    VERDICT_VALID     = 3'd0,
    VERDICT_BAD_UTF8  = 3'd1,
    VERDICT_UNSAFE    = 3'd2,
    VERDICT_TOO_LARGE = 3'd3,
    VERDICT_EMPTY     = 3'd4
  } verdict_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_LIMIT = 2'd0,
    CFG_CP_LIMIT   = 2'd1,
    CFG_ALLOW_WS   = 2'd2,
    CFG_NONEMPTY   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] byte_limit;
    logic [LIMIT_W-1:0] cp_limit;
    logic               allow_ws;
    logic               need_nonempty;
  } cfg_t;

  typedef struct packed {
    logic [1:0]            pending;
    logic [2:0]            seq_width;
    logic [CP_W-1:0]       partial;
    logic [BYTE_CNT_W-1:0] byte_total;
    logic [COUNT_BITS-1:0] cp_total;
    verdict_e              first_err;
  } text_state_t;

  typedef struct packed {
    verdict_e              verdict;
    logic [CP_OUT_W-1:0]   cp_seen;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/utv_in_if.sv @@
// Interface: input channel, one text byte per word.
`timescale 1ns / 1ps
`default_nettype none

interface utv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_text;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_text, output ready);
endinterface

`default_nettype wire

@@ rtl/core/utv_out_if.sv @@
// Interface: result channel, one status word per text.
`timescale 1ns / 1ps
`default_nettype none

interface utv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] codepoints_seen;

  modport source (output valid, output verdict, output codepoints_seen, input ready);
  modport sink   (input valid, input verdict, input codepoints_seen, output ready);
endinterface

`default_nettype wire

@@ rtl/core/utv_cfg.sv @@
// Configuration register file of the UTF-8 text validator.
`timescale 1ns / 1ps
`default_nettype none

module utv_cfg
  import utv_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BYTE_LIMIT: cfg_d.byte_limit    = cfg_data_i[LIMIT_W-1:0];
        CFG_CP_LIMIT:   cfg_d.cp_limit      = cfg_data_i[LIMIT_W-1:0];
        CFG_ALLOW_WS:   cfg_d.allow_ws      = cfg_data_i[0];
        CFG_NONEMPTY:   cfg_d.need_nonempty = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_limit    <= '1;
      cfg_q.cp_limit      <= '1;
      cfg_q.allow_ws      <= 1'b0;
      cfg_q.need_nonempty <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/utv_step.sv @@
// Per-byte decode step: next text state and end-of-text status.
`timescale 1ns / 1ps
`default_nettype none

module utv_step
  import utv_pkg::*;
(
  input  wire text_state_t state_i,
  input  wire cfg_t        cfg_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_text_i,
  output text_state_t      state_o,
  output result_t          result_o
);

  text_state_t upd;

  // Judge a complete codepoint; returns the error code or VERDICT_VALID
  function automatic verdict_e judge_cp(logic [CP_W-1:0] cp, logic [2:0] width,
                                        logic allow_ws, logic [COUNT_BITS-1:0] total,
                                        logic [LIMIT_W-1:0] limit);
    logic ws;
    verdict_e res;
    ws = allow_ws && (cp == CP_TAB || cp == CP_NEWLINE);
    if ((width == 3'd2 && cp < CP_MIN_2) || (width == 3'd3 && cp < CP_MIN_3) ||
        (width == 3'd4 && cp < CP_MIN_4) ||
        (cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp > CP_MAX) begin
      res = VERDICT_BAD_UTF8;
    end else if (cp == '0 || (cp < CP_C0_END && !ws) ||
                 (cp >= CP_DEL && cp <= CP_C1_HI)) begin
      res = VERDICT_UNSAFE;
    end else if (CMP_W'(total) >= CMP_W'(limit)) begin
      res = VERDICT_TOO_LARGE;
    end else begin
      res = VERDICT_VALID;
    end
    return res;
  endfunction

  // Byte intake and UTF-8 decode
  always_comb begin
    logic            finish;
    logic [CP_W-1:0] cp;
    verdict_e        err;
    upd    = state_i;
    finish = 1'b0;
    cp     = CP_W'(data_byte_i);
    err    = VERDICT_VALID;
    if (byte_present_i) begin
      if (state_i.byte_total != '1) begin
        upd.byte_total = state_i.byte_total + BYTE_CNT_W'(1);
      end
      if (state_i.first_err == VERDICT_VALID) begin
        if (state_i.pending == 2'd0) begin
          if (!data_byte_i[7]) begin
            finish        = 1'b1;
            upd.seq_width = 3'd1;
          end else if (data_byte_i[7:5] == 3'b110) begin
            upd.seq_width = 3'd2;
            upd.pending   = 2'd1;
            upd.partial   = CP_W'(data_byte_i[4:0]);
          end else if (data_byte_i[7:4] == 4'b1110) begin
            upd.seq_width = 3'd3;
            upd.pending   = 2'd2;
            upd.partial   = CP_W'(data_byte_i[3:0]);
          end else if (data_byte_i[7:3] == 5'b11110) begin
            upd.seq_width = 3'd4;
            upd.pending   = 2'd3;
            upd.partial   = CP_W'(data_byte_i[2:0]);
          end else begin
            upd.first_err = VERDICT_BAD_UTF8;
          end
        end else if (data_byte_i[7:6] != 2'b10) begin
          upd.first_err = VERDICT_BAD_UTF8;
          upd.pending   = 2'd0;
        end else begin
          upd.partial = {state_i.partial[CP_W-7:0], data_byte_i[5:0]};
          upd.pending = state_i.pending - 2'd1;
          cp          = upd.partial;
          finish      = (state_i.pending == 2'd1);
        end
      end
    end
    // single-byte sequences keep the stored width; judge with the actual width
    if (finish) begin
      err = judge_cp(cp, (state_i.pending == 2'd0) ? 3'd1 : state_i.seq_width,
                     cfg_i.allow_ws, state_i.cp_total, cfg_i.cp_limit);
      if (err != VERDICT_VALID) begin
        upd.first_err = err;
      end else if (state_i.cp_total != '1) begin
        upd.cp_total = state_i.cp_total + COUNT_BITS'(1);
      end
    end
    if (state_i.pending == 2'd0 && upd.seq_width == 3'd1) begin
      upd.seq_width = state_i.seq_width;
    end
  end

  // Status at end of text, priority order
  always_comb begin
    result_o.cp_seen = CP_OUT_W'(CMP_W'(upd.cp_total));
    if (cfg_i.need_nonempty && upd.byte_total == '0) begin
      result_o.verdict = VERDICT_EMPTY;
    end else if (CMP_W'(upd.byte_total) > CMP_W'(cfg_i.byte_limit)) begin
      result_o.verdict = VERDICT_TOO_LARGE;
    end else if (upd.first_err != VERDICT_VALID) begin
      result_o.verdict = upd.first_err;
    end else if (upd.pending != 2'd0) begin
      result_o.verdict = VERDICT_BAD_UTF8;
    end else begin
      result_o.verdict = VERDICT_VALID;
    end
  end

  // Text state clears after the closing word
  always_comb begin
    if (end_of_text_i) begin
      state_o           = '0;
      state_o.first_err = VERDICT_VALID;
    end else begin
      state_o = upd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utv_text_validator_core.sv @@
// Datapath core: input register, text state, decode step and result register.
`timescale 1ns / 1ps
`default_nettype none

module utv_text_validator_core
  import utv_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  utv_in_if.sink          in_i,
  utv_out_if.source       out_o
);

  logic        stg_valid_q;
  logic [7:0]  stg_byte_q;
  logic        stg_present_q;
  logic        stg_end_q;
  logic        stg_adv;
  text_state_t st_q, st_d;
  result_t     res;
  logic        out_valid_q;
  result_t     out_res_q;

  // Staged word moves on unless it closes a text and the result slot is busy
  assign stg_adv  = stg_valid_q && (!stg_end_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !stg_valid_q || stg_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      stg_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_byte_q    <= in_i.data_byte;
      stg_present_q <= in_i.byte_present;
      stg_end_q     <= in_i.end_of_text;
    end
  end

  utv_step u_step (
    .state_i        (st_q),
    .cfg_i          (cfg_i),
    .data_byte_i    (stg_byte_q),
    .byte_present_i (stg_present_q),
    .end_of_text_i  (stg_end_q),
    .state_o        (st_d),
    .result_o       (res)
  );

  // Text state register; all-zero is the empty text with no error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (stg_adv) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_adv && stg_end_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_adv && stg_end_q) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.verdict         = out_res_q.verdict;
  assign out_o.codepoints_seen = out_res_q.cp_seen;

  // A pending continuation count always stays below the sequence width
  a_pending_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.pending != 2'd0) |-> (st_q.seq_width > {1'b0, st_q.pending}))
    else $error("pending count not below sequence width");

  // Once an error is latched, decoding stops
  a_err_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_adv && !stg_end_q && st_q.first_err != VERDICT_VALID) |=>
    ($stable(st_q.pending) && $stable(st_q.partial) && $stable(st_q.cp_total)))
    else $error("decode state moved after an error");

  // Input stalls only behind a closing word waiting on a full result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (stg_valid_q && stg_end_q && out_valid_q && !out_o.ready))
    else $error("input stalled without cause");

  // Closing word leaves a clean text state
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_adv && stg_end_q) |=> (st_q.byte_total == '0 && st_q.pending == 2'd0 &&
                                st_q.first_err == VERDICT_VALID))
    else $error("text state not cleared after end of text");

endmodule

`default_nettype wire

@@ rtl/core/utf8_text_validator.sv @@
// UTF-8 text validator: accepts one byte per word, reports one status per text.
// Channels: in_i carries data_byte, byte_present and end_of_text; a word with
// byte_present low and end_of_text high closes the text, empty if no byte came
// before. out_o carries one word per text: verdict (0 valid, 1 invalid UTF-8, 2
// unsafe control, 3 too large, 4 empty) and codepoints_seen. Configuration is a
// plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) that the user is to use only
// while no text is in flight; the block does not enforce this. Throughput: one
// word per cycle unless a closing word waits on a full result slot, set by the
// combinational decode step between the input register and the text state
// register. The status is registered: input register, then result register.
// Reset clears the text state and result slot and loads the registers with byte
// and codepoint limits of 65535, whitespace disallowed and empty texts allowed.
// When the receiver stalls, non-closing words keep flowing; a closing word waits
// in the input register until the result slot frees, holding ready low till then.
`timescale 1ns / 1ps
`default_nettype none

module utf8_text_validator
  import utv_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  utv_in_if.sink                     in_i,
  utv_out_if.source                  out_o
);

  cfg_t cfg;

  utv_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  utv_text_validator_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ sim/utf8_text_validator_tb.sv @@
// Testbench: UTF-8 text validator, each status checked against a behavioral predictor.
`timescale 1ns / 1ps

module utf8_text_validator_tb;
  import utv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } text_word_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Configuration port
  logic                  cfg_we = 1'b0;
  cfg_idx_e              cfg_idx = CFG_BYTE_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Channel drive registers, known from time zero
  logic       drv_valid = 1'b0;
  logic [7:0] drv_data = '0;
  logic       drv_present = 1'b0;
  logic       drv_last = 1'b0;
  logic       rcv_ready = 1'b0;

  utv_in_if  in_if ();
  utv_out_if out_if ();

  assign in_if.valid        = drv_valid;
  assign in_if.data_byte    = drv_data;
  assign in_if.byte_present = drv_present;
  assign in_if.end_of_text  = drv_last;
  assign out_if.ready       = rcv_ready;

  utf8_text_validator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register copies seen by the predictor
  logic [LIMIT_W-1:0] byte_cap = 16'hFFFF;
  logic [LIMIT_W-1:0] cp_cap = 16'hFFFF;
  logic               ws_allowed = 1'b0;
  logic               empty_is_error = 1'b0;

  // Predicted decoder state of the text in flight
  logic [1:0]            dec_left = '0;
  logic [2:0]            dec_width = '0;
  logic [CP_W-1:0]       dec_value = '0;
  logic [BYTE_CNT_W-1:0] text_bytes = '0;
  logic [COUNT_BITS-1:0] text_cps = '0;
  verdict_e              text_err = VERDICT_VALID;

  text_word_t unsent_words_q[$];
  result_t    pending_status_q[$];

  int  queued_words = 0;
  int  gen_text_len = 0;
  int  mismatch_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  // Judge one decoded codepoint
  function automatic void judge_codepoint(input logic [CP_W-1:0] cp, input logic [2:0] width);
    logic ws;
    ws = ws_allowed && (cp == CP_TAB || cp == CP_NEWLINE);
    if ((width == 3'd2 && cp < CP_MIN_2) || (width == 3'd3 && cp < CP_MIN_3) ||
        (width == 3'd4 && cp < CP_MIN_4) || (cp >= CP_SURR_LO && cp <= CP_SURR_HI) ||
        cp > CP_MAX) begin
      text_err = VERDICT_BAD_UTF8;
    end else if (cp == '0 || (cp < CP_C0_END && !ws) || (cp >= CP_DEL && cp <= CP_C1_HI)) begin
      text_err = VERDICT_UNSAFE;
    end else if (({1'b0, text_cps} + 17'd1) > {1'b0, cp_cap}) begin
      text_err = VERDICT_TOO_LARGE;
    end else if (text_cps != {COUNT_BITS{1'b1}}) begin
      text_cps = text_cps + 1'b1;
    end
  endfunction

  // Byte counting and sequence decode; decode stops at the first error
  function automatic void decode_text_byte(input logic [7:0] b);
    if (text_bytes != {BYTE_CNT_W{1'b1}}) text_bytes = text_bytes + 1'b1;
    if (text_err == VERDICT_VALID) begin
      if (dec_left == 2'd0) begin
        if (b <= 8'h7F) begin
          judge_codepoint(CP_W'(b), 3'd1);
        end else if (b[7:5] == 3'b110) begin
          dec_width = 3'd2; dec_left = 2'd1; dec_value = CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          dec_width = 3'd3; dec_left = 2'd2; dec_value = CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          dec_width = 3'd4; dec_left = 2'd3; dec_value = CP_W'(b[2:0]);
        end else begin
          text_err = VERDICT_BAD_UTF8;
        end
      end else if (b[7:6] != 2'b10) begin
        text_err = VERDICT_BAD_UTF8;
        dec_left = 2'd0;
      end else begin
        dec_value = {dec_value[CP_W-7:0], b[5:0]};
        dec_left = dec_left - 2'd1;
        if (dec_left == 2'd0) judge_codepoint(dec_value, dec_width);
      end
    end
  endfunction

  // Predict the effect of one accepted word; a closing word yields a status
  function automatic void apply_text_word(input logic [7:0] data, input logic present,
                                          input logic last);
    result_t st;
    if (present) decode_text_byte(data);
    if (last) begin
      if (empty_is_error && text_bytes == '0) st.verdict = VERDICT_EMPTY;
      else if (text_bytes > {1'b0, byte_cap}) st.verdict = VERDICT_TOO_LARGE;
      else if (text_err != VERDICT_VALID) st.verdict = text_err;
      else if (dec_left != 2'd0) st.verdict = VERDICT_BAD_UTF8;
      else st.verdict = VERDICT_VALID;
      st.cp_seen = text_cps;
      pending_status_q = {pending_status_q, st};
      dec_left = '0;
      dec_width = '0;
      dec_value = '0;
      text_bytes = '0;
      text_cps = '0;
      text_err = VERDICT_VALID;
    end
  endfunction

  // Stimulus building
  function automatic void push_word(input logic [7:0] data, input logic present,
                                    input logic last);
    text_word_t w;
    w.data = data;
    w.present = present;
    w.last = last;
    unsent_words_q = {unsent_words_q, w};
    if (present || last) queued_words++;
    if (present) gen_text_len++;
    if (last) gen_text_len = 0;
  endfunction

  // First n bytes of a width-w encoding of cp (overlong and out of range allowed)
  function automatic void push_seq(input int w, input logic [CP_W-1:0] cp, input int n);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      if (k == 0) begin
        case (w)
          1: b = cp[7:0];
          2: b = {3'b110, cp[10:6]};
          3: b = {4'b1110, cp[15:12]};
          default: b = {5'b11110, cp[20:18]};
        endcase
      end else begin
        b = {2'b10, 6'(cp >> (6 * (w - 1 - k)))};
      end
      push_word(b, 1'b1, 1'b0);
    end
  endfunction

  function automatic int seq_len_for(input logic [CP_W-1:0] cp);
    if (cp < CP_MIN_2) return 1;
    if (cp < CP_MIN_3) return 2;
    if (cp < CP_MIN_4) return 3;
    return 4;
  endfunction

  function automatic void push_cp(input logic [CP_W-1:0] cp);
    push_seq(seq_len_for(cp), cp, seq_len_for(cp));
  endfunction

  // Close the text on its final byte or with a bare end mark
  function automatic void close_text();
    text_word_t w;
    if (gen_text_len != 0 && $urandom_range(0, 1) == 1) begin
      w = unsent_words_q.pop_back();
      w.last = 1'b1;
      unsent_words_q = {unsent_words_q, w};
      queued_words += w.present ? 0 : 1;
      gen_text_len = 0;
    end else begin
      push_word(8'($urandom), 1'b0, 1'b1);
    end
  endfunction

  function automatic logic [CP_W-1:0] random_cp();
    logic [CP_W-1:0] cp;
    case ($urandom_range(0, 10))
      0, 1, 2, 3: cp = CP_W'($urandom_range(16'h20, 16'h7E));
      4: cp = ($urandom_range(0, 1) == 1) ? CP_TAB : CP_NEWLINE;
      5: cp = CP_W'($urandom_range(16'hA0, 16'h7FF));
      6: begin
        cp = CP_W'($urandom_range(16'h800, 16'hFFFF));
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp ^ 21'h004000;
      end
      7: cp = CP_W'($urandom_range(32'h10000, 32'h10FFFF));
      8: cp = CP_W'($urandom_range(0, 16'hFF));
      default: begin
        case ($urandom_range(0, 7))
          0: cp = CP_DEL;
          1: cp = CP_MIN_2;
          2: cp = CP_C1_HI;
          3: cp = CP_MIN_3 - 1'b1;
          4: cp = CP_MIN_3;
          5: cp = CP_MIN_4 - 1'b1;
          6: cp = CP_MIN_4;
          default: cp = CP_MAX;
        endcase
      end
    endcase
    return cp;
  endfunction

  // One random text: mostly well formed, sometimes with a fault or a cut end
  function automatic void queue_random_text(input int fault_pct);
    int n_cp;
    int w;
    logic [CP_W-1:0] cp;
    n_cp = $urandom_range(0, 10);
    for (int i = 0; i < n_cp; i++) begin
      push_cp(random_cp());
      if ($urandom_range(0, 9) == 0) push_word(8'($urandom), 1'b0, 1'b0);
      if ($urandom_range(0, 99) < fault_pct) begin
        w = $urandom_range(2, 4);
        case ($urandom_range(0, 6))
          0: push_word(($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                   : 8'($urandom_range(8'hF8, 8'hFF)),
                       1'b1, 1'b0);
          1: begin
            push_seq(w, CP_MAX, $urandom_range(1, w - 1));
            push_word(($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 8'h7F))
                                                  : 8'($urandom_range(8'hC0, 8'hFF)),
                      1'b1, 1'b0);
          end
          2: begin
            cp = (w == 2) ? CP_MIN_2 : (w == 3) ? CP_MIN_3 : CP_MIN_4;
            push_seq(w, CP_W'($urandom_range(0, 32'(cp) - 1)), w);
          end
          3: push_seq(3, CP_W'($urandom_range(16'hD800, 16'hDFFF)), 3);
          4: push_seq(4, CP_W'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
          5: push_cp(($urandom_range(0, 1) == 1) ? CP_W'($urandom_range(0, 8'h1F))
                                                 : CP_W'($urandom_range(8'h7F, 8'h9F)));
          default: repeat ($urandom_range(1, 4)) push_word(8'($urandom), 1'b1, 1'b0);
        endcase
      end
    end
    if ($urandom_range(0, 19) == 0) begin
      w = $urandom_range(2, 4);
      push_seq(w, CP_MAX, $urandom_range(1, w - 1));
    end
    close_text();
  endfunction

  function automatic void queue_random_words(input int count, input int fault_pct);
    int goal;
    goal = queued_words + count;
    while (queued_words < goal) queue_random_text(fault_pct);
  endfunction

  // Printable ASCII text of n bytes, closed on its final byte
  function automatic void queue_ascii_run(input int n);
    for (int i = 1; i < n; i++) push_word(8'($urandom_range(8'h20, 8'h7E)), 1'b1, 1'b0);
    push_word(8'($urandom_range(8'h20, 8'h7E)), 1'b1, 1'b1);
  endfunction

  task automatic set_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_BYTE_LIMIT: byte_cap = data;
      CFG_CP_LIMIT:   cp_cap = data;
      CFG_ALLOW_WS:   ws_allowed = data[0];
      CFG_NONEMPTY:   empty_is_error = data[0];
      default: ;
    endcase
  endtask

  // One-bit register value with random upper bits, which the block ignores
  function automatic logic [CFG_DATA_W-1:0] flag_word(input logic bit_val);
    return {15'($urandom), bit_val};
  endfunction

  task automatic wait_until_drained();
    while (unsent_words_q.size() != 0 || drv_valid || pending_status_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Word driver: takes the next pending word, inserts idle bursts
  always @(posedge clk_i) begin : word_driver
    text_word_t w;
    if (!rst_ni) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_if.ready) apply_text_word(drv_data, drv_present, drv_last);
      if (!drv_valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          drv_valid <= 1'b0;
        end else if (unsent_words_q.size() != 0) begin
          w = unsent_words_q.pop_front();
          drv_valid <= 1'b1;
          drv_data <= w.data;
          drv_present <= w.present;
          drv_last <= w.last;
          if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: checks each accepted status word against the oldest prediction
  always @(posedge clk_i) begin : status_monitor
    result_t due_status;
    if (rst_ni) begin
      if (out_if.valid && rcv_ready) begin
        if (pending_status_q.size() == 0) begin
          report_mismatch($sformatf("status word with no closed text: verdict %0d cps %0d",
                                    out_if.verdict, out_if.codepoints_seen));
        end else begin
          due_status = pending_status_q.pop_front();
          if (out_if.verdict !== due_status.verdict)
            report_mismatch($sformatf("verdict %0d, predicted %0d (%s)", out_if.verdict,
                                      due_status.verdict, due_status.verdict.name()));
          if (out_if.codepoints_seen !== due_status.cp_seen)
            report_mismatch($sformatf("codepoints_seen %0d, predicted %0d",
                                      out_if.codepoints_seen, due_status.cp_seen));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rcv_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= 1'b1;
      end
    end
  end

  // Run limit
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Phases: directed texts then random ones, registers changed between phases
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Reset settings: empty allowed, whitespace off, full limits
    @(negedge clk_i);
    push_word(8'h5A, 1'b0, 1'b1);                    // empty text is fine
    push_word(8'h09, 1'b1, 1'b1);                    // tab is unsafe here
    push_word(8'h41, 1'b1, 1'b0);
    push_word(8'hFF, 1'b0, 1'b0);                    // bare mark, ignored
    push_cp(CP_MAX);
    push_cp(CP_MIN_3 - 1'b1);
    push_word(8'h00, 1'b0, 1'b1);
    push_seq(2, '0, 2);                              // overlong NUL, then more bytes
    push_word(8'h41, 1'b1, 1'b1);
    push_seq(3, CP_SURR_LO, 3);
    push_word(8'h41, 1'b1, 1'b1);
    push_seq(4, CP_MAX + 1'b1, 4);
    push_word(8'h00, 1'b0, 1'b1);
    push_seq(2, CP_C1_HI, 2);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h7F, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'h80, 1'b1, 1'b1);                    // stray continuation as lead
    push_seq(3, 21'h0020AC, 1);                      // lead then a non-continuation
    push_word(8'h41, 1'b1, 1'b1);
    push_seq(3, 21'h0020AC, 2);                      // text ends inside a sequence
    push_word(8'h00, 1'b0, 1'b1);
    queue_random_words(200, 10);
    wait_until_drained();

    // Small limits, whitespace allowed, empty text rejected
    set_register(CFG_BYTE_LIMIT, 16'd6);
    set_register(CFG_CP_LIMIT, 16'd3);
    set_register(CFG_ALLOW_WS, flag_word(1'b1));
    set_register(CFG_NONEMPTY, flag_word(1'b1));
    @(posedge clk_i) cfg_we <= 1'b0;
    @(negedge clk_i);
    push_word(8'h09, 1'b1, 1'b0);
    push_word(8'h0A, 1'b1, 1'b1);
    push_word(8'h00, 1'b0, 1'b1);                    // empty text now an error
    queue_ascii_run(4);                              // fourth codepoint over the limit
    push_word(8'h80, 1'b1, 1'b0);                    // byte excess outranks bad UTF-8
    queue_ascii_run(6);
    queue_random_words(100, 15);
    wait_until_drained();

    // Zero limits
    set_register(CFG_BYTE_LIMIT, 16'd0);
    set_register(CFG_CP_LIMIT, 16'd0);
    set_register(CFG_NONEMPTY, flag_word(1'b0));
    @(posedge clk_i) cfg_we <= 1'b0;
    @(negedge clk_i);
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h41, 1'b1, 1'b1);
    queue_random_words(40, 15);
    wait_until_drained();

    // Random mid-range settings
    for (int p = 0; p < 3; p++) begin
      set_register(CFG_BYTE_LIMIT, 16'($urandom_range(4, 60)));
      set_register(CFG_CP_LIMIT, 16'($urandom_range(2, 30)));
      set_register(CFG_ALLOW_WS, flag_word(1'($urandom)));
      set_register(CFG_NONEMPTY, flag_word(1'($urandom)));
      @(posedge clk_i) cfg_we <= 1'b0;
      @(negedge clk_i);
      queue_random_words(100, 15);
      wait_until_drained();
    end

    // Full limits, no idling: random texts back to back
    set_register(CFG_BYTE_LIMIT, 16'hFFFF);
    set_register(CFG_CP_LIMIT, 16'hFFFF);
    set_register(CFG_ALLOW_WS, flag_word(1'($urandom)));
    set_register(CFG_NONEMPTY, flag_word(1'($urandom)));
    @(posedge clk_i) cfg_we <= 1'b0;
    calm = 1'b1;
    @(negedge clk_i);
    queue_random_words(160, 10);
    wait_until_drained();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
